// File: rtl/i2cm_pkg.sv
package i2cm_pkg;

    // Default width of the segment hold timer
    localparam int TIMER_BITS_DEF = 17;

    // Half unit length after reset, in ticks
    localparam logic [15:0] HALF_RESET = 16'd50;

    // Command codes carried in the kind field
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_WRITE   = 3'd4,
        CMD_READ    = 3'd5
    } t_cmd;

    // Result of one tick, handed from the sequencer to the output register
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } t_res;

endpackage

// File: rtl/i2cm_in_if.sv
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, kind, tx_byte, send_ack, sda_in, input ready);
    modport sink   (input valid, kind, tx_byte, send_ack, sda_in, output ready);
endinterface

// File: rtl/i2cm_out_if.sv
interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;

    modport source (output valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                     rx_byte, ack_missing, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                     rx_byte, ack_missing, output ready);
endinterface

// File: rtl/i2cm_seq.sv
module i2cm_seq #(
    parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [2:0]      i_kind,
    input  logic [7:0]      i_tx_byte,
    input  logic            i_send_ack,
    input  logic            i_sda_in,
    input  logic [15:0]     i_half,
    output i2cm_pkg::t_res  o_res
);
    import i2cm_pkg::*;

    localparam int LEN_W = (TIMER_BITS > 17) ? TIMER_BITS : 17;

    typedef logic [3:0] t_step;

    // Segment numbers of each sequence
    localparam t_step ST_SCL_LO   = 4'd0;
    localparam t_step ST_SDA_HI   = 4'd1;
    localparam t_step ST_SCL_HI   = 4'd2;
    localparam t_step ST_SDA_LO   = 4'd3;
    localparam t_step ST_LAST     = 4'd4;
    localparam t_step RS_SDA_HI   = 4'd0;
    localparam t_step RS_SCL_HI   = 4'd1;
    localparam t_step RS_SDA_LO   = 4'd2;
    localparam t_step RS_LAST     = 4'd3;
    localparam t_step SP_LOW      = 4'd0;
    localparam t_step SP_SCL_HI   = 4'd1;
    localparam t_step SP_LAST     = 4'd2;
    localparam t_step WR_BIT      = 4'd0;
    localparam t_step WR_SCL_HI   = 4'd1;
    localparam t_step WR_SCL_LO   = 4'd2;
    localparam t_step WR_HOLD     = 4'd3;
    localparam t_step WR_REL      = 4'd4;
    localparam t_step WR_ACK_HI   = 4'd5;
    localparam t_step WR_ACK_HOLD = 4'd6;
    localparam t_step WR_ACK_LO   = 4'd7;
    localparam t_step WR_LAST     = 4'd8;
    localparam t_step RD_SAMPLE   = 4'd0;
    localparam t_step RD_LOW      = 4'd1;
    localparam t_step RD_ACK_HI   = 4'd2;
    localparam t_step RD_LAST     = 4'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic en;
        logic sda;
        logic scl;
    } t_pins;

    typedef struct packed {
        t_pins pins;
        logic  two;
    } t_enter;

    // Pin change of a segment and whether it holds two half units
    function automatic t_enter enter_seg(t_cmd cmd, t_step s, t_pins p, logic msb,
                                         logic ack_ch);
        t_enter e;
        e.pins = p;
        e.two  = 1'b1;
        unique case (cmd)
            CMD_START: begin
                if (s == ST_SCL_LO) begin
                    e.pins.scl = 1'b0;
                    e.pins.en  = 1'b1;
                    e.two      = 1'b0;
                end else if (s == ST_SDA_HI) begin
                    e.pins.sda = 1'b1;
                end else if (s == ST_SCL_HI) begin
                    e.pins.scl = 1'b1;
                end else if (s == ST_SDA_LO) begin
                    e.pins.sda = 1'b0;
                end else begin
                    e.pins.scl = 1'b0;
                end
            end
            CMD_RESTART: begin
                if (s == RS_SDA_HI) begin
                    e.pins.en  = 1'b1;
                    e.pins.sda = 1'b1;
                end else if (s == RS_SCL_HI) begin
                    e.pins.scl = 1'b1;
                end else if (s == RS_SDA_LO) begin
                    e.pins.sda = 1'b0;
                end else begin
                    e.pins.scl = 1'b0;
                end
            end
            CMD_STOP: begin
                if (s == SP_LOW) begin
                    e.pins.en  = 1'b1;
                    e.pins.scl = 1'b0;
                    e.pins.sda = 1'b0;
                end else if (s == SP_SCL_HI) begin
                    e.pins.scl = 1'b1;
                end else begin
                    e.pins.sda = 1'b1;
                end
            end
            CMD_WRITE: begin
                unique case (s)
                    WR_BIT: begin
                        e.pins.en  = 1'b1;
                        e.pins.sda = msb;
                        e.two      = 1'b0;
                    end
                    WR_SCL_HI: e.pins.scl = 1'b1;
                    WR_SCL_LO: begin
                        e.pins.scl = 1'b0;
                        e.two      = 1'b0;
                    end
                    WR_HOLD: e.two = 1'b0;
                    WR_REL: begin
                        e.pins.sda = 1'b1;
                        e.pins.en  = 1'b0;
                        e.two      = 1'b0;
                    end
                    WR_ACK_HI: e.pins.scl = 1'b1;
                    WR_ACK_HOLD: e.two = 1'b0;
                    WR_ACK_LO: begin
                        e.pins.scl = 1'b0;
                        e.two      = 1'b0;
                    end
                    default: begin
                        e.pins.en = 1'b1;
                        e.two     = 1'b0;
                    end
                endcase
            end
            default: begin
                if (s == RD_SAMPLE) begin
                    e.pins.sda = 1'b1;
                    e.pins.en  = 1'b0;
                    e.pins.scl = 1'b1;
                end else if (s == RD_LOW) begin
                    e.pins.scl = 1'b0;
                end else if (s == RD_ACK_HI) begin
                    e.pins.en  = 1'b1;
                    e.pins.sda = !ack_ch;
                    e.pins.scl = 1'b1;
                end else begin
                    e.pins.scl = 1'b0;
                    e.pins.sda = 1'b1;
                end
            end
        endcase
        return e;
    endfunction

    // Segment length in ticks, zero half unit read as one, saturated to the timer
    function automatic logic [TIMER_BITS-1:0] seg_len(logic [15:0] half, logic two);
        logic [15:0]      h;
        logic [LEN_W-1:0] t;
        logic [LEN_W-1:0] tmax;
        h    = (half == 16'd0) ? 16'd1 : half;
        t    = LEN_W'(two ? {h, 1'b0} : {1'b0, h});
        tmax = LEN_W'({TIMER_BITS{1'b1}});
        if (t > tmax) begin
            t = tmax;
        end
        return t[TIMER_BITS-1:0];
    endfunction

    t_cmd                  r_cmd, n_cmd;
    t_step                 r_seg, n_seg;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [3:0]            r_bits, n_bits;
    logic [7:0]            r_shift, n_shift;
    logic [7:0]            r_rx, n_rx;
    logic                  r_ack, n_ack;
    t_pins                 r_pins, n_pins;
    logic                  r_ack_ch, n_ack_ch;

    // Work out one tick: take a command, count down, end or enter a segment
    always_comb begin
        t_enter e;
        t_pins  shown;
        logic   last;
        t_step  nxt;

        n_cmd    = r_cmd;
        n_seg    = r_seg;
        n_timer  = r_timer;
        n_bits   = r_bits;
        n_shift  = r_shift;
        n_rx     = r_rx;
        n_ack    = r_ack;
        n_pins   = r_pins;
        n_ack_ch = r_ack_ch;
        last     = 1'b0;
        nxt      = 4'd0;
        e        = '0;

        o_res          = '0;

        // Take a new command when idle
        if (r_cmd == CMD_NONE && i_kind >= 3'(CMD_START) && i_kind <= 3'(CMD_READ)) begin
            n_cmd  = t_cmd'(i_kind);
            n_seg  = 4'd0;
            n_bits = 4'd0;
            if (t_cmd'(i_kind) == CMD_WRITE) begin
                n_shift = i_tx_byte;
            end else if (t_cmd'(i_kind) == CMD_READ) begin
                n_shift  = 8'd0;
                n_ack_ch = i_send_ack;
            end
            e       = enter_seg(n_cmd, n_seg, n_pins, n_shift[7], n_ack_ch);
            n_pins  = e.pins;
            n_timer = seg_len(i_half, e.two);
        end

        shown = n_pins;

        // Count down the segment and act at its end
        if (n_cmd != CMD_NONE) begin
            o_res.busy_res = 1'b1;
            if (n_timer != '0) begin
                n_timer = n_timer - 1'b1;
            end
            if (n_timer == '0) begin
                nxt = 4'(n_seg + 4'd1);
                unique case (n_cmd)
                    CMD_START:   last = (n_seg >= ST_LAST);
                    CMD_RESTART: last = (n_seg >= RS_LAST);
                    CMD_STOP:    last = (n_seg >= SP_LAST);
                    CMD_WRITE: begin
                        if (n_seg == WR_SCL_LO) begin
                            n_shift = {n_shift[6:0], 1'b0};
                            n_bits  = n_bits + 4'd1;
                            nxt     = (n_bits < BITS_PER_BYTE) ? WR_BIT : WR_HOLD;
                        end else if (n_seg == WR_ACK_HI) begin
                            n_ack = i_sda_in;
                        end
                        last = (n_seg >= WR_LAST);
                    end
                    default: begin
                        if (n_seg == RD_SAMPLE) begin
                            n_shift = {n_shift[6:0], i_sda_in};
                        end else if (n_seg == RD_LOW) begin
                            n_bits = n_bits + 4'd1;
                            if (n_bits < BITS_PER_BYTE) begin
                                nxt = RD_SAMPLE;
                            end else begin
                                n_rx = n_shift;
                                nxt  = RD_ACK_HI;
                            end
                        end
                        last = (n_seg >= RD_LAST);
                    end
                endcase
                if (last) begin
                    o_res.done_res = 1'b1;
                    n_cmd          = CMD_NONE;
                    n_seg          = 4'd0;
                end else begin
                    n_seg   = nxt;
                    e       = enter_seg(n_cmd, n_seg, n_pins, n_shift[7], n_ack_ch);
                    n_pins  = e.pins;
                    n_timer = seg_len(i_half, e.two);
                end
            end
        end

        o_res.scl_level   = shown.scl;
        o_res.sda_level   = shown.sda;
        o_res.sda_enable  = shown.en;
        o_res.rx_byte     = n_rx;
        o_res.ack_missing = n_ack;
    end

    // Hold the sequencer state; advance on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd    <= CMD_NONE;
            r_seg    <= 4'd0;
            r_timer  <= '0;
            r_bits   <= 4'd0;
            r_shift  <= 8'd0;
            r_rx     <= 8'd0;
            r_ack    <= 1'b0;
            r_pins   <= '{en: 1'b1, sda: 1'b0, scl: 1'b0};
            r_ack_ch <= 1'b0;
        end else if (i_step) begin
            r_cmd    <= n_cmd;
            r_seg    <= n_seg;
            r_timer  <= n_timer;
            r_bits   <= n_bits;
            r_shift  <= n_shift;
            r_rx     <= n_rx;
            r_ack    <= n_ack;
            r_pins   <= n_pins;
            r_ack_ch <= n_ack_ch;
        end
    end

endmodule

// File: rtl/i2c_master_byte_engine_unit.sv
// I2C master pin sequencer, one input word per system tick.
// Input channel i_in: each word is one tick of bus time, carrying an optional
// command (start, repeated start, stop, write byte, read byte), the byte to send,
// the ack choice for reads and the sampled SDA level. Commands that arrive while
// a sequence runs, including on its done tick, are ignored.
// Output channel o_out: one word per input word with the SCL/SDA drive, SDA
// enable, busy and done flags, the last received byte and the missing-ack flag.
// Each result is registered and valid in the cycle after its word is accepted.
// Throughput: one word per cycle unless stalled; the state update and result
// are worked out in a single pass from the sequencer registers into the output
// register. When the receiver stalls, the output register holds its word and
// i_in.ready drops only while that word is still waiting, so nothing is lost.
// i_cfg_wr_en/i_cfg_wr_data set the half unit length in ticks; write it only
// while no sequence runs. Reset leaves the sequencer idle, SCL and SDA driven
// low with SDA enabled, a half unit of 50 ticks and the output register empty.
module i2c_master_byte_engine_unit #(
    parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cm_in_if.sink     i_in,
    i2cm_out_if.source  o_out,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);
    import i2cm_pkg::*;

    logic [15:0] r_half;
    logic        r_out_valid;
    t_res        r_res;
    t_res        seq_res;
    logic        in_take;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_take    = i_in.valid && i_in.ready;

    // Half unit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
        end else if (i_cfg_wr_en) begin
            r_half <= i_cfg_wr_data;
        end
    end

    i2cm_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (in_take),
        .i_kind     (i_in.kind),
        .i_tx_byte  (i_in.tx_byte),
        .i_send_ack (i_in.send_ack),
        .i_sda_in   (i_in.sda_in),
        .i_half     (r_half),
        .o_res      (seq_res)
    );

    // Output register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= seq_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.scl_level   = r_res.scl_level;
    assign o_out.sda_level   = r_res.sda_level;
    assign o_out.sda_enable  = r_res.sda_enable;
    assign o_out.busy_res    = r_res.busy_res;
    assign o_out.done_res    = r_res.done_res;
    assign o_out.rx_byte     = r_res.rx_byte;
    assign o_out.ack_missing = r_res.ack_missing;

endmodule

// File: tb/tb_i2c_master_byte_engine_unit.sv
// Tick-level model of the I2C master sequencer: predicts the pin word of every
// accepted tick and checks the words that come out, in order.
class i2c_pin_scoreboard;

    logic [15:0]     half_ticks;
    i2cm_pkg::t_cmd  cur_cmd;
    int unsigned     seg;
    longint unsigned hold_left;
    bit [3:0]        bit_cnt;
    bit [7:0]        shreg;
    bit [7:0]        rx_reg;
    bit              ack_miss;
    bit              ack_sel;
    bit              scl_q;
    bit              sda_q;
    bit              en_q;

    i2cm_pkg::t_res  words_due[$];
    int unsigned     n_mismatch;
    int unsigned     n_checked;
    int unsigned     n_cmds;

    function new();
        half_ticks = i2cm_pkg::HALF_RESET;
        cur_cmd    = i2cm_pkg::CMD_NONE;
        seg        = 0;
        hold_left  = 0;
        bit_cnt    = '0;
        shreg      = '0;
        rx_reg     = '0;
        ack_miss   = 1'b0;
        ack_sel    = 1'b0;
        scl_q      = 1'b0;
        sda_q      = 1'b0;
        en_q       = 1'b1;
        n_mismatch = 0;
        n_checked  = 0;
        n_cmds     = 0;
    endfunction

    function void set_half(logic [15:0] v);
        half_ticks = v;
    endfunction

    function bit is_idle();
        return cur_cmd == i2cm_pkg::CMD_NONE;
    endfunction

    function int unsigned pending();
        return words_due.size();
    endfunction

    // Load the segment hold; a zero half unit counts as one tick, saturate at timer width
    function void load_hold(int unsigned units);
        longint unsigned h;
        longint unsigned t;
        longint unsigned top;
        h   = (half_ticks == 16'd0) ? 64'd1 : 64'(half_ticks);
        t   = h * units;
        top = (64'd1 << i2cm_pkg::TIMER_BITS_DEF) - 64'd1;
        if (t > top)
            t = top;
        hold_left = t;
    endfunction

    // Apply the pin change of the segment just entered
    function void enter_seg();
        int unsigned units;
        units = 2;
        case (cur_cmd)
            i2cm_pkg::CMD_START: begin
                case (seg)
                    0: begin scl_q = 1'b0; en_q = 1'b1; units = 1; end
                    1: sda_q = 1'b1;
                    2: scl_q = 1'b1;
                    3: sda_q = 1'b0;
                    default: scl_q = 1'b0;
                endcase
            end
            i2cm_pkg::CMD_RESTART: begin
                case (seg)
                    0: begin en_q = 1'b1; sda_q = 1'b1; end
                    1: scl_q = 1'b1;
                    2: sda_q = 1'b0;
                    default: scl_q = 1'b0;
                endcase
            end
            i2cm_pkg::CMD_STOP: begin
                case (seg)
                    0: begin en_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0; end
                    1: scl_q = 1'b1;
                    default: sda_q = 1'b1;
                endcase
            end
            i2cm_pkg::CMD_WRITE: begin
                case (seg)
                    0: begin en_q = 1'b1; sda_q = shreg[7]; units = 1; end
                    1: scl_q = 1'b1;
                    2: begin scl_q = 1'b0; units = 1; end
                    3: units = 1;
                    4: begin sda_q = 1'b1; en_q = 1'b0; units = 1; end
                    5: scl_q = 1'b1;
                    6: units = 1;
                    7: begin scl_q = 1'b0; units = 1; end
                    default: begin en_q = 1'b1; units = 1; end
                endcase
            end
            default: begin
                case (seg)
                    0: begin sda_q = 1'b1; en_q = 1'b0; scl_q = 1'b1; end
                    1: scl_q = 1'b0;
                    2: begin en_q = 1'b1; sda_q = ~ack_sel; scl_q = 1'b1; end
                    default: begin scl_q = 1'b0; sda_q = 1'b1; end
                endcase
            end
        endcase
        load_hold(units);
    endfunction

    // Act on the end of a segment; return 1 when the sequence is over
    function bit finish_seg(bit sda);
        int unsigned nxt;
        bit          last;
        nxt  = seg + 1;
        last = 1'b0;
        case (cur_cmd)
            i2cm_pkg::CMD_START:   last = (seg >= 4);
            i2cm_pkg::CMD_RESTART: last = (seg >= 3);
            i2cm_pkg::CMD_STOP:    last = (seg >= 2);
            i2cm_pkg::CMD_WRITE: begin
                if (seg == 2) begin
                    shreg   = shreg << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    nxt     = (bit_cnt < 4'd8) ? 0 : 3;
                end else if (seg == 5) begin
                    ack_miss = sda;
                end
                last = (seg >= 8);
            end
            default: begin
                if (seg == 0) begin
                    shreg = {shreg[6:0], sda};
                end else if (seg == 1) begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < 4'd8) begin
                        nxt = 0;
                    end else begin
                        rx_reg = shreg;
                        nxt    = 2;
                    end
                end
                last = (seg >= 3);
            end
        endcase
        seg = nxt & 63;
        return last;
    endfunction

    // Advance the sequencer by one accepted tick and queue its pin word
    function void note_tick(logic [2:0] kind, logic [7:0] tx, logic sack, logic sda);
        i2cm_pkg::t_res w;
        bit             busy;
        bit             done;
        busy = 1'b0;
        done = 1'b0;
        if (cur_cmd == i2cm_pkg::CMD_NONE && kind >= i2cm_pkg::CMD_START &&
            kind <= i2cm_pkg::CMD_READ) begin
            cur_cmd = i2cm_pkg::t_cmd'(kind);
            seg     = 0;
            bit_cnt = '0;
            if (cur_cmd == i2cm_pkg::CMD_WRITE) begin
                shreg = tx;
            end else if (cur_cmd == i2cm_pkg::CMD_READ) begin
                shreg   = '0;
                ack_sel = sack;
            end
            enter_seg();
            n_cmds++;
        end
        w.scl_level  = scl_q;
        w.sda_level  = sda_q;
        w.sda_enable = en_q;
        if (cur_cmd != i2cm_pkg::CMD_NONE) begin
            busy = 1'b1;
            if (hold_left > 0)
                hold_left--;
            if (hold_left == 0) begin
                if (finish_seg(sda)) begin
                    done    = 1'b1;
                    cur_cmd = i2cm_pkg::CMD_NONE;
                    seg     = 0;
                end else begin
                    enter_seg();
                end
            end
        end
        w.busy_res    = busy;
        w.done_res    = done;
        w.rx_byte     = rx_reg;
        w.ack_missing = ack_miss;
        words_due.push_back(w);
    endfunction

    task report_mismatch(string msg);
        n_mismatch++;
        if (n_mismatch <= 40)
            $display("MISMATCH: %s", msg);
    endtask

    // Compare one output word with the oldest predicted word
    task check_word(i2cm_pkg::t_res got);
        i2cm_pkg::t_res want;
        if (words_due.size() == 0) begin
            report_mismatch("output word with no tick waiting");
            return;
        end
        want = words_due.pop_front();
        n_checked++;
        if (got.scl_level !== want.scl_level)
            report_mismatch($sformatf("word %0d scl_level got %b want %b",
                                      n_checked, got.scl_level, want.scl_level));
        if (got.sda_level !== want.sda_level)
            report_mismatch($sformatf("word %0d sda_level got %b want %b",
                                      n_checked, got.sda_level, want.sda_level));
        if (got.sda_enable !== want.sda_enable)
            report_mismatch($sformatf("word %0d sda_enable got %b want %b",
                                      n_checked, got.sda_enable, want.sda_enable));
        if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("word %0d busy_res got %b want %b",
                                      n_checked, got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
            report_mismatch($sformatf("word %0d done_res got %b want %b",
                                      n_checked, got.done_res, want.done_res));
        if (got.rx_byte !== want.rx_byte)
            report_mismatch($sformatf("word %0d rx_byte got %h want %h",
                                      n_checked, got.rx_byte, want.rx_byte));
        if (got.ack_missing !== want.ack_missing)
            report_mismatch($sformatf("word %0d ack_missing got %b want %b",
                                      n_checked, got.ack_missing, want.ack_missing));
    endtask

endclass

module tb_i2c_master_byte_engine_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int         CYCLE_LIMIT  = 3000000;
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam int         SDA_LOW      = 0;
    localparam int         SDA_HIGH     = 1;
    localparam int         SDA_RAND     = 2;
    localparam int         PHASE_TICKS  = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    i2cm_in_if  in_if();
    i2cm_out_if out_if();

    i2c_pin_scoreboard sb;

    bit          idle_on;
    bit          noise_on;
    int unsigned n_ticks;
    int unsigned cyc_count;

    i2c_master_byte_engine_unit #(
        .TIMER_BITS(TIMER_BITS_DEF)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .o_out        (out_if),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic pick_sda(int mode);
        if (mode == SDA_LOW)
            return 1'b0;
        if (mode == SDA_HIGH)
            return 1'b1;
        return 1'($urandom);
    endfunction

    // Drive one tick word and hold it until the block takes it
    task automatic send_tick(input logic [2:0] kind, input logic [7:0] tx,
                             input logic sack, input logic sda);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.kind     <= kind;
        in_if.tx_byte  <= tx;
        in_if.send_ack <= sack;
        in_if.sda_in   <= sda;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        sb.note_tick(kind, tx, sack, sda);
        n_ticks++;
    endtask

    // Idle ticks, with the unused kinds mixed in
    task automatic idle_ticks(input int n);
        int         r;
        logic [2:0] kind;
        repeat (n) begin
            r    = $urandom_range(0, 3);
            kind = (r == 0) ? KIND_SPARE_A : (r == 1) ? KIND_SPARE_B : CMD_NONE;
            send_tick(kind, 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // Issue a command from idle and tick until it completes
    task automatic run_cmd(input t_cmd cmd, input logic [7:0] tx, input logic sack,
                           input int sda_mode);
        send_tick(cmd, tx, sack, pick_sda(sda_mode));
        while (!sb.is_idle()) begin
            // commands landing mid-sequence must be dropped
            if (noise_on && $urandom_range(0, 7) == 0)
                send_tick(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom),
                          pick_sda(sda_mode));
            else
                send_tick(CMD_NONE, 8'($urandom), 1'($urandom), pick_sda(sda_mode));
        end
    endtask

    // Drain all words, then write the half unit length while idle
    task automatic set_half_units(input logic [15:0] v);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        sb.set_half(v);
    endtask

    function automatic int pick_mode();
        int r;
        r = $urandom_range(0, 3);
        return (r == 0) ? SDA_LOW : (r == 1) ? SDA_HIGH : SDA_RAND;
    endfunction

    // Mostly well-formed transfers with random content, some broken ones
    task automatic random_transfer();
        int n;
        if ($urandom_range(0, 9) < 8) begin
            run_cmd(CMD_START, 8'($urandom), 1'($urandom), SDA_RAND);
            idle_ticks($urandom_range(0, 2));
            run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), pick_mode());
            n = $urandom_range(0, 2);
            repeat (n) begin
                idle_ticks($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 0)
                    run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), pick_mode());
                else
                    run_cmd(CMD_READ, 8'($urandom), 1'($urandom), pick_mode());
            end
            if ($urandom_range(0, 3) == 0) begin
                run_cmd(CMD_RESTART, 8'($urandom), 1'($urandom), SDA_RAND);
                run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), pick_mode());
                run_cmd(CMD_READ, 8'($urandom), 1'($urandom), pick_mode());
            end
            idle_ticks($urandom_range(0, 2));
            run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RAND);
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                idle_ticks($urandom_range(0, 3));
                run_cmd(t_cmd'($urandom_range(1, 5)), 8'($urandom), 1'($urandom),
                        pick_mode());
            end
        end
    endtask

    // Take output words with random stalls and check each one
    initial begin
        int hold;
        i2cm_pkg::t_res got;
        hold = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.scl_level   = out_if.scl_level;
                got.sda_level   = out_if.sda_level;
                got.sda_enable  = out_if.sda_enable;
                got.busy_res    = out_if.busy_res;
                got.done_res    = out_if.done_res;
                got.rx_byte     = out_if.rx_byte;
                got.ack_missing = out_if.ack_missing;
                sb.check_word(got);
            end
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    // Stop a hung run
    initial begin
        cyc_count = 0;
        while (cyc_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc_count++;
        end
        $display("timeout after %0d cycles", cyc_count);
        $display("[i2c_master_byte_engine_unit] ERROR");
        $finish;
    end

    initial begin
        logic [15:0] phase_half[6];
        int          ph;
        int unsigned phase_end;

        sb       = new();
        idle_on  = 1'b1;
        noise_on = 1'b0;
        n_ticks  = 0;
        phase_half[0] = 16'd1;
        phase_half[1] = 16'd2;
        phase_half[2] = 16'd0;
        phase_half[3] = 16'd3;
        phase_half[4] = 16'd1;
        phase_half[5] = 16'd2;

        i_rst_n        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        in_if.valid    <= 1'b0;
        in_if.kind     <= CMD_NONE;
        in_if.tx_byte  <= '0;
        in_if.send_ack <= 1'b0;
        in_if.sda_in   <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset timing, then a zero half unit with every command kind
        idle_ticks(3);
        run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND);
        set_half_units(16'd0);
        idle_ticks(4);
        run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND);
        run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW);
        run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH);
        run_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND);
        run_cmd(CMD_READ, 8'h00, 1'b1, SDA_HIGH);
        run_cmd(CMD_READ, 8'hFF, 1'b0, SDA_LOW);
        run_cmd(CMD_READ, 8'h3C, 1'b1, SDA_RAND);
        noise_on = 1'b1;
        run_cmd(CMD_RESTART, 8'h00, 1'b0, SDA_RAND);
        run_cmd(CMD_WRITE, 8'h5A, 1'b0, SDA_LOW);
        run_cmd(CMD_READ, 8'hC3, 1'b0, SDA_RAND);
        run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND);
        noise_on = 1'b0;

        // Random transfers over several half unit settings
        noise_on = 1'b1;
        for (ph = 0; ph < 6; ph++) begin
            set_half_units(phase_half[ph]);
            idle_on   = (ph != 3);
            phase_end = n_ticks + PHASE_TICKS;
            while (n_ticks < phase_end)
                random_transfer();
        end
        idle_on = 1'b1;

        // Drain and let any stray word show up
        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("ran %0d ticks with %0d commands started, %0d output words checked",
                 n_ticks, sb.n_checked == 0 ? 0 : sb.n_cmds, sb.n_checked);
        $display("half unit settings 50, 0, 1, 2, 3; %0d mismatches",
                 sb.n_mismatch);
        if (sb.n_mismatch == 0)
            $display("[i2c_master_byte_engine_unit] OK");
        else
            $display("[i2c_master_byte_engine_unit] ERROR");
        $finish;
    end

endmodule

// File: i2c_master_byte_engine_unit.f
rtl/i2cm_pkg.sv
rtl/i2cm_in_if.sv
rtl/i2cm_out_if.sv
rtl/i2cm_seq.sv
rtl/i2c_master_byte_engine_unit.sv
tb/tb_i2c_master_byte_engine_unit.sv
